[rtl/oaht_pkg.sv]
// package for the open address hash table
// shared types, codes and constants; no dependencies
package oaht_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int KEY_BYTES_DEF  = 8;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [63:0] FNV_OFFSET = 64'd2166136261;

    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_PUT     = 3'd1,
        OP_ADD     = 3'd2,
        OP_REPLACE = 3'd3,
        OP_CAS     = 3'd4,
        OP_DELETE  = 3'd5,
        OP_CLEAR   = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_MISMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY     = 2'd0,
        MARK_OCCUPIED  = 2'd1,
        MARK_TOMBSTONE = 2'd2
    } mark_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_MUL,
        S_MOD,
        S_ISSUE,
        S_WAIT,
        S_CHECK,
        S_ACT,
        S_RMW,
        S_CLEAR,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic mul_step;
        logic mod_init;
        logic mod_step;
        logic probe_init;
        logic probe_adv;
        logic rd_issue;
        logic do_act;
        logic do_rmw;
        logic clr_step;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic mod_done;
        logic is_empty;
        logic is_hit;
        logic lap_done;
        logic clr_done;
        logic need_rmw;
        logic is_clear;
        logic bad_op;
    } dp_stat_t;

endpackage

[rtl/open_address_hash_table.sv]
// top level of the open address hash table
// depends on oaht_pkg, oaht_ctrl, oaht_dp, oaht_ram
//
// One operation at a time: start is taken when busy is low, and one result
// word appears with done high for a single cycle; the receiver cannot stall
// it. After the accepting edge busy stays high while the key bytes before
// the first zero byte are hashed (64-bit hash), through the bit-serial modulo
// by the slot count, then while each probed slot is read through the
// registered slot memories, an extra step for read-modify-write operations,
// and a final cycle in which done is high. Clear sweeps every slot mark, and
// the pass after reset holds busy high while it sweeps all slot marks one
// per cycle. Registers at 0x0: table_slots.
module open_address_hash_table #(
    parameter int CAPACITY   = oaht_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [63:0] key,
    input  logic [31:0] value,
    input  logic [31:0] expected,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] value_out,
    output logic [8:0]  entries_out,
    output logic [8:0]  tombstones_out
);
    import oaht_pkg::*;

    logic [8:0] slots_reg;
    ctl_cmd_t   cmd;
    dp_stat_t   stat;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {23'd0, slots_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 9'd256;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            slots_reg <= pwdata[8:0];
        end
    end

    oaht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd)
    );

    oaht_dp #(
        .CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .op(op), .key(key), .value(value), .expected(expected),
        .slots_cfg(slots_reg), .done(done), .status(status),
        .value_out(value_out), .entries_out(entries_out),
        .tombstones_out(tombstones_out)
    );
endmodule

[rtl/oaht_ram.sv]
// generic single write port ram with registered read
// no dependencies
module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/oaht_ctrl.sv]
// controller state machine of the hash table
// depends on oaht_pkg
module oaht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  oaht_pkg::dp_stat_t stat,
    output oaht_pkg::ctl_cmd_t cmd
);
    import oaht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_INIT:
            begin
                // sweep after reset, no result word
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.bad_op)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.hash_done)
                begin
                    cmd.mod_init = 1'b1;
                    state_next   = S_MOD;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_HASH;
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_ISSUE;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.is_hit || stat.is_empty || stat.lap_done)
                begin
                    cmd.do_act = 1'b1;
                    state_next = stat.need_rmw ? S_RMW : S_DONE;
                    cmd.finish = !stat.need_rmw;
                end
                else
                begin
                    cmd.probe_adv = 1'b1;
                    state_next    = S_ISSUE;
                end
            end
            S_RMW:
            begin
                cmd.do_rmw = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !busy)
        else $error("busy while idle");
    a_load_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_HASH))
        else $error("load not followed by hash");
    a_rmw_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW) |-> $past(state_reg == S_CHECK))
        else $error("rmw out of order");
endmodule

[rtl/oaht_dp.sv]
// datapath of the hash table: hash, modulo, probe and slot stores
// depends on oaht_pkg and oaht_ram
module oaht_dp #(
    parameter int CAPACITY   = oaht_pkg::CAPACITY_DEF,
    parameter int KEY_BYTES  = oaht_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  oaht_pkg::ctl_cmd_t cmd,
    output oaht_pkg::dp_stat_t stat,
    input  logic [2:0]         op,
    input  logic [63:0]        key,
    input  logic [31:0]        value,
    input  logic [31:0]        expected,
    input  logic [8:0]         slots_cfg,
    output logic               done,
    output logic [2:0]         status,
    output logic [31:0]        value_out,
    output logic [8:0]         entries_out,
    output logic [8:0]         tombstones_out
);
    import oaht_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int NW  = AW + 1;
    localparam int KW  = 8 * KEY_BYTES;
    localparam int BCW = $clog2(KEY_BYTES + 1);
    localparam int RW  = 64 + NW;

    // operand latch
    logic [2:0]            op_reg;
    logic [KW-1:0]         key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, exp_reg;
    logic [NW-1:0]         n_reg;

    // hash
    logic [63:0]  h_reg;
    logic [BCW-1:0] bcnt_reg;
    logic         hdone_reg;
    logic [KW-1:0] kshift_reg;

    // restoring modulo, one bit per cycle
    logic [RW-1:0] rem_reg;
    logic [6:0]    mcnt_reg;

    // probe
    logic [AW-1:0] idx_reg, spot_reg, where_reg;
    logic          spot_ok_reg, hit_reg;
    logic [NW-1:0] step_reg;
    logic [AW-1:0] clr_reg;

    logic [8:0]    live_reg, tomb_reg;

    logic [2:0]    status_reg;
    logic [31:0]   vout_reg;
    logic          done_reg;

    // stores
    logic          mk_we, kv_we, val_we;
    logic [AW-1:0] mk_wa, kv_wa, rd_a;
    logic [1:0]    mk_wd, mk_rd;
    logic [KW-1:0] key_rd;
    logic [VALUE_BITS-1:0] val_wd, val_rd;

    function automatic logic [VALUE_BITS-1:0] to_stored(input logic [31:0] f);
        logic [63:0] x;
        x = {{32{f[31]}}, f};
        return x[VALUE_BITS-1:0];
    endfunction

    function automatic logic [31:0] to_output(input logic [VALUE_BITS-1:0] s);
        logic [63:0] x;
        x = 64'(signed'(s));
        return x[31:0];
    endfunction

    // key normalization: cut at first zero byte
    always_comb
    begin
        logic z;
        key_next = '0;
        z        = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (key[8*i +: 8] == 8'd0)
            begin
                z = 1'b1;
            end
            if (!z)
            begin
                key_next[8*i +: 8] = key[8*i +: 8];
            end
        end
    end

    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (slots_cfg == 9'd0)
        begin
            n_eff = NW'(1);
        end
        else if ({23'd0, slots_cfg} > CAPACITY)
        begin
            n_eff = NW'(CAPACITY);
        end
        else
        begin
            n_eff = NW'(slots_cfg);
        end
    end

    logic [RW-1:0] rem_sh, n_ext;
    assign rem_sh = rem_reg << 1;
    assign n_ext  = {{(RW-NW){1'b0}}, n_reg} << 64;

    logic [AW-1:0] idx_inc;
    assign idx_inc = ({1'b0, idx_reg} + NW'(1) >= n_reg) ? '0 : AW'(idx_reg + AW'(1));

    logic slot_hit;
    assign slot_hit = (mk_rd == MARK_OCCUPIED) && (key_rd == key_reg);

    // a free slot for an insert: a tombstone passed earlier, or the current one
    logic slot_free;
    assign slot_free = spot_ok_reg || (mk_rd != MARK_OCCUPIED);

    logic [VALUE_BITS-1:0] sum_val;
    assign sum_val = val_rd + val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            tomb_reg <= '0;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load && op == OP_CLEAR)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= AW'(clr_reg + AW'(1));
                if (stat.clr_done)
                begin
                    live_reg <= '0;
                    tomb_reg <= '0;
                end
            end
            if (cmd.do_act && !hit_reg && !slot_hit && op_reg == OP_DELETE)
            begin
                // nothing
            end
            if (cmd.do_act && slot_hit && op_reg == OP_DELETE)
            begin
                if (live_reg != 9'd0)
                begin
                    live_reg <= live_reg - 9'd1;
                end
                tomb_reg <= tomb_reg + 9'd1;
            end
            if (cmd.do_act && !slot_hit && (op_reg == OP_PUT || op_reg == OP_ADD)
                && slot_free)
            begin
                live_reg <= live_reg + 9'd1;
                if ((spot_ok_reg || mk_rd == MARK_TOMBSTONE) && tomb_reg != 9'd0)
                begin
                    tomb_reg <= tomb_reg - 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            key_reg    <= key_next;
            kshift_reg <= key_next;
            val_reg    <= to_stored(value);
            exp_reg    <= to_stored(expected);
            n_reg      <= n_eff;
            h_reg      <= FNV_OFFSET;
            bcnt_reg   <= '0;
            hdone_reg  <= 1'b0;
            status_reg <= ST_MISS;
            vout_reg   <= '0;
        end
        if (cmd.hash_step)
        begin
            h_reg      <= h_reg ^ {56'd0, kshift_reg[7:0]};
            kshift_reg <= kshift_reg >> 8;
            bcnt_reg   <= BCW'(bcnt_reg + BCW'(1));
        end
        if (cmd.mul_step)
        begin
            // fnv prime 2^24 + 0x193 as shifts and adds
            h_reg <= (h_reg << 24) + (h_reg << 8) + (h_reg << 7) + (h_reg << 4)
                     + (h_reg << 1) + h_reg;
            if ({{(32-BCW){1'b0}}, bcnt_reg} >= KEY_BYTES || kshift_reg[7:0] == 8'd0)
            begin
                hdone_reg <= 1'b1;
            end
        end
        if (cmd.load && key_next[7:0] == 8'd0)
        begin
            hdone_reg <= 1'b1;
        end
        if (cmd.mod_init)
        begin
            rem_reg  <= {{NW{1'b0}}, h_reg};
            mcnt_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= (rem_sh >= n_ext) ? (rem_sh - n_ext) : rem_sh;
            mcnt_reg <= mcnt_reg + 7'd1;
        end
        if (cmd.probe_init)
        begin
            idx_reg     <= rem_reg[64 +: AW];
            step_reg    <= '0;
            spot_ok_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        if (cmd.probe_adv)
        begin
            if (mk_rd == MARK_TOMBSTONE && !spot_ok_reg)
            begin
                spot_reg    <= idx_reg;
                spot_ok_reg <= 1'b1;
            end
            idx_reg  <= idx_inc;
            step_reg <= NW'(step_reg + NW'(1));
        end
        if (cmd.do_act)
        begin
            where_reg <= idx_reg;
            hit_reg   <= slot_hit;
            if (slot_hit)
            begin
                case (op_reg)
                    OP_GET, OP_REPLACE:
                    begin
                        status_reg <= ST_HIT;
                        vout_reg   <= to_output(val_rd);
                    end
                    OP_CAS:
                    begin
                        vout_reg   <= to_output(val_rd);
                        status_reg <= (val_rd == exp_reg) ? ST_HIT : ST_MISMATCH;
                    end
                    OP_PUT, OP_ADD, OP_DELETE:
                    begin
                        status_reg <= ST_HIT;
                    end
                    default:
                    begin
                        status_reg <= ST_MISS;
                    end
                endcase
            end
            else if (op_reg == OP_PUT || op_reg == OP_ADD)
            begin
                status_reg <= slot_free ? ST_INSERTED : ST_FULL;
            end
        end
        if (cmd.clr_step && stat.clr_done)
        begin
            status_reg <= ST_HIT;
        end
    end

    // write-side selection
    logic [AW-1:0] ins_a;
    logic          ins;
    assign ins_a = spot_ok_reg ? spot_reg : idx_reg;
    assign ins   = cmd.do_act && !slot_hit && (op_reg == OP_PUT || op_reg == OP_ADD)
                   && slot_free;

    always_comb
    begin
        mk_we  = 1'b0;
        mk_wa  = ins_a;
        mk_wd  = MARK_OCCUPIED;
        kv_we  = ins;
        kv_wa  = ins_a;
        val_we = 1'b0;
        val_wd = val_reg;
        if (cmd.clr_step)
        begin
            mk_we = 1'b1;
            mk_wa = clr_reg;
            mk_wd = MARK_EMPTY;
        end
        else if (ins)
        begin
            mk_we  = 1'b1;
            val_we = 1'b1;
        end
        else if (cmd.do_act && slot_hit && op_reg == OP_DELETE)
        begin
            mk_we = 1'b1;
            mk_wa = idx_reg;
            mk_wd = MARK_TOMBSTONE;
        end
        if (cmd.do_rmw)
        begin
            val_we = hit_reg;
            kv_wa  = where_reg;
            if (op_reg == OP_ADD)
            begin
                val_wd = sum_val;
            end
            else if (op_reg == OP_CAS)
            begin
                val_we = hit_reg && (status_reg == ST_HIT);
            end
        end
    end

    assign rd_a = idx_reg;

    oaht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_mark (
        .clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
        .raddr(rd_a), .rdata(mk_rd)
    );
    oaht_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(kv_we), .waddr(kv_wa), .wdata(key_reg),
        .raddr(rd_a), .rdata(key_rd)
    );
    oaht_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(val_we), .waddr(kv_wa), .wdata(val_wd),
        .raddr(rd_a), .rdata(val_rd)
    );

    assign stat.hash_done = hdone_reg;
    assign stat.mod_done  = (mcnt_reg == 7'd64);
    assign stat.is_empty  = (mk_rd == MARK_EMPTY);
    assign stat.is_hit    = slot_hit;
    assign stat.lap_done  = (NW'(step_reg + NW'(1)) >= n_reg);
    assign stat.clr_done  = (clr_reg == AW'(CAPACITY - 1));
    assign stat.need_rmw  = slot_hit && (op_reg == OP_PUT || op_reg == OP_ADD
                            || op_reg == OP_REPLACE || op_reg == OP_CAS);
    assign stat.is_clear  = (op_reg == OP_CLEAR);
    assign stat.bad_op    = (op_reg == 3'd7);

    assign done           = done_reg;
    assign status         = status_reg;
    assign value_out      = vout_reg;
    assign entries_out    = live_reg;
    assign tombstones_out = tomb_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg + tomb_reg) <= 10'(CAPACITY))
        else $error("slot counts exceed capacity");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_step && stat.clr_done) |=> (live_reg == 9'd0 && tomb_reg == 9'd0))
        else $error("clear left counts");
    a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_init |-> (rem_reg[64 +: NW] < n_reg))
        else $error("home slot out of range");
endmodule

[tb/open_address_hash_table_test.sv]
// testbench for open_address_hash_table: directed table plus random traffic,
// every result word checked against the row's fixed reply or a behavioral model of the table
// depends on oaht_pkg and the open_address_hash_table rtl
module open_address_hash_table_test;
    import oaht_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [1:0] REG_TABLE_SLOTS = 2'd0;
    localparam int NSLOT = 256;

    typedef struct {
        status_t     st;
        logic [31:0] vo;
        logic [8:0]  ent;
        logic [8:0]  tmb;
    } reply_t;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] key;
        logic [31:0] val;
        logic [31:0] cmp;
        bit          fixed;
        reply_t      want;
    } row_t;

    typedef struct {
        logic [63:0] key;
        int          len;
    } pool_key_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    logic [2:0]  op = '0;
    logic [63:0] key = '0;
    logic [31:0] value = '0;
    logic [31:0] expected = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [8:0]  entries_out;
    logic [8:0]  tombstones_out;

    open_address_hash_table uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // table model
    mark_t       m_mark [NSLOT];
    logic [63:0] m_key  [NSLOT];
    logic [31:0] m_val  [NSLOT];
    int          m_live, m_tomb;
    logic [8:0]  m_slots_reg;

    reply_t      pending_replies [$];
    bit          failed = 0;
    bit          idle_on = 1;
    pool_key_t   key_pool [24];

    function automatic reply_t table_step(logic [2:0] opc, logic [63:0] raw,
                                          logic [31:0] val, logic [31:0] cmp);
        reply_t r;
        logic [63:0] h, k, b;
        int n, idx, where, spot, i;
        bit hit, spot_ok, stop;
        h = 64'd2166136261;
        k = '0;
        hit = 0; spot_ok = 0; stop = 0; where = 0; spot = 0;
        for (i = 0; i < 8 && !stop; i++)
        begin
            b = (raw >> (8 * i)) & 64'hFF;
            if (b == 0)
                stop = 1;
            else
            begin
                k |= b << (8 * i);
                h = (h ^ b) * 64'd16777619;
            end
        end
        n = (m_slots_reg == 0) ? 1 : (m_slots_reg > NSLOT) ? NSLOT : int'(m_slots_reg);
        idx = int'(h % 64'(n));
        r.st = ST_MISS;
        r.vo = '0;
        if (opc <= OP_DELETE)
        begin
            stop = 0;
            for (i = 0; i < n && !stop; i++)
            begin
                if (m_mark[idx] == MARK_EMPTY)
                begin
                    if (!spot_ok)
                    begin
                        spot = idx;
                        spot_ok = 1;
                    end
                    stop = 1;
                end
                else if (m_mark[idx] == MARK_OCCUPIED)
                begin
                    if (m_key[idx] == k)
                    begin
                        hit = 1;
                        where = idx;
                        stop = 1;
                    end
                end
                else if (!spot_ok)
                begin
                    spot = idx;
                    spot_ok = 1;
                end
                idx = (idx + 1 >= n) ? 0 : idx + 1;
            end
        end
        case (opc)
            OP_GET:
                if (hit)
                begin
                    r.st = ST_HIT;
                    r.vo = m_val[where];
                end
            OP_PUT, OP_ADD:
                if (hit)
                begin
                    m_val[where] = (opc == OP_PUT) ? val : m_val[where] + val;
                    r.st = ST_HIT;
                end
                else if (spot_ok)
                begin
                    if (m_mark[spot] != MARK_EMPTY && m_tomb > 0)
                        m_tomb--;
                    m_mark[spot] = MARK_OCCUPIED;
                    m_key[spot] = k;
                    m_val[spot] = val;
                    m_live++;
                    r.st = ST_INSERTED;
                end
                else
                    r.st = ST_FULL;
            OP_REPLACE:
                if (hit)
                begin
                    r.vo = m_val[where];
                    m_val[where] = val;
                    r.st = ST_HIT;
                end
            OP_CAS:
                if (hit)
                begin
                    r.vo = m_val[where];
                    if (m_val[where] == cmp)
                    begin
                        m_val[where] = val;
                        r.st = ST_HIT;
                    end
                    else
                        r.st = ST_MISMATCH;
                end
            OP_DELETE:
                if (hit)
                begin
                    m_mark[where] = MARK_TOMBSTONE;
                    if (m_live > 0)
                        m_live--;
                    m_tomb++;
                    r.st = ST_HIT;
                end
            OP_CLEAR:
            begin
                foreach (m_mark[j])
                    m_mark[j] = MARK_EMPTY;
                m_live = 0;
                m_tomb = 0;
                r.st = ST_HIT;
            end
            default: ;
        endcase
        r.ent = 9'(m_live);
        r.tmb = 9'(m_tomb);
        return r;
    endfunction

    // issue one word, wait for it to be taken, queue its expected result
    task automatic issue(logic [2:0] opc, logic [63:0] k, logic [31:0] v, logic [31:0] c,
                         bit fixed, reply_t want);
        reply_t r;
        int gap;
        if (idle_on && $urandom_range(0, 99) < 19)
        begin
            gap = $urandom_range(1, 20);
            start <= 0;
            // let the block go free so the gap is real idle time
            do @(posedge clk); while (busy);
            repeat (gap - 1) @(posedge clk);
        end
        start <= 1;
        op <= opc;
        key <= k;
        value <= v;
        expected <= c;
        do @(posedge clk); while (busy);
        r = table_step(opc, k, v, c);
        pending_replies.push_back(fixed ? want : r);
    endtask

    task automatic drain();
        start <= 0;
        while (pending_replies.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_slots(logic [31:0] v);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= REG_TABLE_SLOTS;
        pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        m_slots_reg = v[8:0];
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result word, status %0d", $time, status);
                failed = 1;
            end
            else
            begin
                reply_t w;
                w = pending_replies.pop_front();
                if (status !== w.st || value_out !== w.vo || entries_out !== w.ent
                    || tombstones_out !== w.tmb)
                begin
                    $display({"%0t: expected st=%0d val=%h ent=%0d tmb=%0d,",
                              " got st=%0d val=%h ent=%0d tmb=%0d"},
                             $time, w.st, w.vo, w.ent, w.tmb,
                             status, value_out, entries_out, tombstones_out);
                    failed = 1;
                end
            end
        end
    end

    function automatic logic [31:0] pick_value();
        logic [31:0] special [5] = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        if ($urandom_range(0, 1))
            return special[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    function automatic logic [63:0] pick_key();
        pool_key_t p;
        logic [63:0] junk;
        if ($urandom_range(0, 99) < 15)
            return {$urandom, $urandom};
        p = key_pool[$urandom_range(0, 23)];
        junk = {$urandom, $urandom};
        // junk after the terminating zero byte must not change the key
        if (p.len < 7 && $urandom_range(0, 1))
            return p.key | (junk << (8 * (p.len + 1)));
        return p.key;
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return OP_GET;
        if (r < 45) return OP_PUT;
        if (r < 57) return OP_ADD;
        if (r < 67) return OP_REPLACE;
        if (r < 79) return OP_CAS;
        if (r < 94) return OP_DELETE;
        if (r < 97) return OP_CLEAR;
        return OP_UNUSED;
    endfunction

    row_t rows [20];
    reply_t none;
    logic [31:0] slot_settings [8] = '{32'd1, 32'd0, 32'd511, 32'd256,
                                      32'd2, 32'd7, 32'd16, 32'd300};

    initial
    begin
        none = '{ST_MISS, 32'd0, 9'd0, 9'd0};
        rows[0]  = '{OP_GET,     64'h41, 32'd0, 32'd0, 1, '{ST_MISS, 32'd0, 9'd0, 9'd0}};
        rows[1]  = '{OP_PUT,     64'h41, 32'h7FFFFFFF, 32'd0, 1,
                     '{ST_INSERTED, 32'd0, 9'd1, 9'd0}};
        rows[2]  = '{OP_ADD,     64'h41, 32'd1, 32'd0, 1, '{ST_HIT, 32'd0, 9'd1, 9'd0}};
        rows[3]  = '{OP_GET,     64'h41, 32'd0, 32'd0, 1, '{ST_HIT, 32'h80000000, 9'd1, 9'd0}};
        rows[4]  = '{OP_REPLACE, 64'h41, 32'hFFFFFFFF, 32'd0, 1,
                     '{ST_HIT, 32'h80000000, 9'd1, 9'd0}};
        rows[5]  = '{OP_CAS,     64'h41, 32'd5, 32'd0, 1,
                     '{ST_MISMATCH, 32'hFFFFFFFF, 9'd1, 9'd0}};
        rows[6]  = '{OP_CAS,     64'h41, 32'd5, 32'hFFFFFFFF, 1,
                     '{ST_HIT, 32'hFFFFFFFF, 9'd1, 9'd0}};
        rows[7]  = '{OP_PUT,     64'h0, 32'h80000000, 32'd0, 1,
                     '{ST_INSERTED, 32'd0, 9'd2, 9'd0}};
        rows[8]  = '{OP_PUT,     64'hFFFFFFFFFFFFFFFF, 32'd3, 32'hFFFFFFFF, 1,
                     '{ST_INSERTED, 32'd0, 9'd3, 9'd0}};
        rows[9]  = '{OP_GET,     64'h00FF00FF, 32'd0, 32'd0, 0, none};
        rows[10] = '{OP_PUT,     64'hAB000000000000FF, 32'd9, 32'd0, 0, none};
        rows[11] = '{OP_GET,     64'h00000000000000FF, 32'd0, 32'd0, 0, none};
        rows[12] = '{OP_DELETE,  64'h41, 32'd0, 32'd0, 0, none};
        rows[13] = '{OP_DELETE,  64'h41, 32'd0, 32'd0, 0, none};
        rows[14] = '{OP_PUT,     64'h41, 32'd77, 32'd0, 0, none};
        rows[15] = '{OP_REPLACE, 64'h1234, 32'd1, 32'd0, 0, none};
        rows[16] = '{OP_CAS,     64'h1234, 32'd1, 32'd1, 0, none};
        rows[17] = '{OP_ADD,     64'h42, 32'hFFFFFFFB, 32'd0, 0, none};
        rows[18] = '{OP_UNUSED,  64'h41, 32'd0, 32'd0, 0, none};
        rows[19] = '{OP_CLEAR,   64'h41, 32'd0, 32'd0, 1, '{ST_HIT, 32'd0, 9'd0, 9'd0}};

        foreach (m_mark[j])
            m_mark[j] = MARK_EMPTY;
        m_live = 0;
        m_tomb = 0;
        m_slots_reg = 9'd256;
        foreach (key_pool[j])
        begin
            key_pool[j].len = $urandom_range(1, 8);
            key_pool[j].key = '0;
            for (int b = 0; b < key_pool[j].len; b++)
                key_pool[j].key |= 64'($urandom_range(1, 255)) << (8 * b);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (rows[j])
            issue(rows[j].op, rows[j].key, rows[j].val, rows[j].cmp,
                  rows[j].fixed, rows[j].want);
        issue(OP_GET, 64'h41, 32'd0, 32'd0, 1, '{ST_MISS, 32'd0, 9'd0, 9'd0});
        drain();

        foreach (slot_settings[s])
        begin
            write_slots(slot_settings[s]);
            idle_on = (s != 3);
            for (int i = 0; i < 110; i++)
                issue(pick_op(), pick_key(), pick_value(), pick_value(), 0, none);
            drain();
        end

        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/oaht_pkg.sv
rtl/oaht_ram.sv
rtl/oaht_ctrl.sv
rtl/oaht_dp.sv
rtl/open_address_hash_table.sv
tb/open_address_hash_table_test.sv
